/* rtl/pdpl_pkg.sv */
`default_nettype none
package pdpl_pkg;

  // Width of the GoodCRC wait timer.
  localparam int TimerWidth = 16;

  // Queue depths; both are powers of two so the pointers wrap naturally.
  localparam int CmdDepth = 2;
  localparam int ResDepth = 4;
  localparam int CmdPtrW = $clog2(CmdDepth);
  localparam int ResPtrW = $clog2(ResDepth);
  localparam int CmdCntW = $clog2(CmdDepth + 1);
  localparam int ResCntW = $clog2(ResDepth + 1);

  // Configuration register indexes.
  localparam logic [1:0] CFG_PHY_GOODCRC = 2'd0;
  localparam logic [1:0] CFG_MONITOR     = 2'd1;
  localparam logic [1:0] CFG_RETRY_LIMIT = 2'd2;
  localparam logic [1:0] CFG_CRC_TIMEOUT = 2'd3;

  // Event codes carried by a result.
  localparam logic [2:0] EV_NONE         = 3'd0;
  localparam logic [2:0] EV_RESET        = 3'd1;
  localparam logic [2:0] EV_MSG_RECEIVED = 3'd2;
  localparam logic [2:0] EV_TX_FAILED    = 3'd3;
  localparam logic [2:0] EV_CONNECTED    = 3'd4;
  localparam logic [2:0] EV_DISCONNECTED = 3'd5;

  // Input event codes.
  typedef enum logic [2:0] {
    OP_RESET   = 3'd0,
    OP_SEND    = 3'd1,
    OP_TX_DONE = 3'd2,
    OP_RX_MSG  = 3'd3,
    OP_TICK    = 3'd4,
    OP_CC      = 3'd5
  } op_t;

  // One classified request as it travels from the front to the back.
  typedef struct packed {
    op_t        op;
    logic       msg_is_goodcrc;
    logic [2:0] rx_message_id;
    logic       rx_is_sop;
    logic [1:0] rx_spec_rev;
    logic       tx_ok;
    logic [1:0] cc_line;
  } cmd_t;

  // One result as it waits in the output queue.
  typedef struct packed {
    logic       transmit;
    logic [2:0] tx_message_id;
    logic [1:0] tx_spec_rev;
    logic       tx_is_goodcrc;
    logic [1:0] tx_cc;
    logic       send_accepted;
    logic [2:0] event_code;
    logic       last;
  } res_t;

endpackage
`default_nettype wire

/* rtl/pdpl_front.sv */
`default_nettype none
module pdpl_front (
  input  wire logic            push,
  input  wire logic            full,
  input  wire logic [2:0]      op,
  input  wire logic            msg_is_goodcrc,
  input  wire logic [2:0]      rx_message_id,
  input  wire logic            rx_is_sop,
  input  wire logic [1:0]      rx_spec_rev,
  input  wire logic            tx_ok,
  input  wire logic [1:0]      cc_line,
  output logic                 wr_en,
  output pdpl_pkg::cmd_t       wr_cmd
);

  logic known;

  // Classify the op code; unused codes are accepted and dropped here.
  assign known = (op inside {pdpl_pkg::OP_RESET, pdpl_pkg::OP_SEND, pdpl_pkg::OP_TX_DONE,
                             pdpl_pkg::OP_RX_MSG, pdpl_pkg::OP_TICK, pdpl_pkg::OP_CC});

  assign wr_en = push && !full && known;

  always_comb begin
    wr_cmd.op             = pdpl_pkg::op_t'(op);
    wr_cmd.msg_is_goodcrc = msg_is_goodcrc;
    wr_cmd.rx_message_id  = rx_message_id;
    wr_cmd.rx_is_sop      = rx_is_sop;
    wr_cmd.rx_spec_rev    = rx_spec_rev;
    wr_cmd.tx_ok          = tx_ok;
    wr_cmd.cc_line        = cc_line;
  end

endmodule
`default_nettype wire

/* rtl/pdpl_cmd_queue.sv */
`default_nettype none
module pdpl_cmd_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wr_en,
  input  wire pdpl_pkg::cmd_t  wr_cmd,
  output logic                 full,
  input  wire logic            rd_en,
  output logic                 rd_valid,
  output pdpl_pkg::cmd_t       rd_cmd
);

  pdpl_pkg::cmd_t                  slots [pdpl_pkg::CmdDepth];
  logic [pdpl_pkg::CmdPtrW-1:0]    head;
  logic [pdpl_pkg::CmdPtrW-1:0]    tail;
  logic [pdpl_pkg::CmdCntW-1:0]    count;

  assign full     = (count == pdpl_pkg::CmdCntW'(pdpl_pkg::CmdDepth));
  assign rd_valid = (count != '0);
  assign rd_cmd   = slots[head];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        tail <= tail + 1'b1;
      end
      if (rd_en) begin
        head <= head + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  // Request storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[tail] <= wr_cmd;
    end
  end

endmodule
`default_nettype wire

/* rtl/pdpl_res_queue.sv */
`default_nettype none
module pdpl_res_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic [1:0]      wr_count,
  input  wire pdpl_pkg::res_t  wr_res0,
  input  wire pdpl_pkg::res_t  wr_res1,
  output logic                 room,
  output logic                 empty,
  input  wire logic            pop,
  output pdpl_pkg::res_t       rd_res
);

  pdpl_pkg::res_t                  slots [pdpl_pkg::ResDepth];
  logic [pdpl_pkg::ResPtrW-1:0]    head;
  logic [pdpl_pkg::ResPtrW-1:0]    tail;
  logic [pdpl_pkg::ResCntW-1:0]    count;
  logic                            rd_en;

  // Room for the two results that one request can produce at most.
  assign room   = (count <= pdpl_pkg::ResCntW'(pdpl_pkg::ResDepth - 2));
  assign empty  = (count == '0);
  assign rd_en  = pop && !empty;
  assign rd_res = slots[head];

  // Pointers and fill count; up to two writes and one read per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail + pdpl_pkg::ResPtrW'(wr_count);
      if (rd_en) begin
        head <= head + 1'b1;
      end
      count <= count + pdpl_pkg::ResCntW'(wr_count) - pdpl_pkg::ResCntW'(rd_en);
    end
  end

  // Result storage.
  always_ff @(posedge clk) begin
    if (wr_count != 2'd0) begin
      slots[tail] <= wr_res0;
    end
    if (wr_count == 2'd2) begin
      slots[tail + 1'b1] <= wr_res1;
    end
  end

endmodule
`default_nettype wire

/* rtl/pdpl_back.sv */
`default_nettype none
module pdpl_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_valid,
  input  wire logic [1:0]      cfg_index,
  input  wire logic [15:0]     cfg_data,
  input  wire logic            cmd_valid,
  input  wire pdpl_pkg::cmd_t  cmd,
  output logic                 cmd_take,
  input  wire logic            room,
  output logic [1:0]           wr_count,
  output pdpl_pkg::res_t       wr_res0,
  output pdpl_pkg::res_t       wr_res1
);

  localparam int TW = pdpl_pkg::TimerWidth;

  // Configuration registers.
  logic        phy_gc;
  logic        monitor_only;
  logic [2:0]  retry_limit;
  logic [15:0] crc_timeout;

  // Protocol state.
  logic [2:0]    tx_id,        tx_id_next;
  logic [3:0]    retries_left, retries_left_next;
  logic          tx_kind_gc,   tx_kind_gc_next;
  logic [TW-1:0] crc_timer,    crc_timer_next;
  logic [2:0]    last_rx_id,   last_rx_id_next;
  logic          last_rx_valid, last_rx_valid_next;
  logic [1:0]    spec_rev,     spec_rev_next;
  logic          pending,      pending_next;
  logic [1:0]    cc_pin,       cc_pin_next;

  logic [TW-1:0] timer_load;
  logic [TW-1:0] timer_dec;
  logic [3:0]    retries_dec;
  logic [3:0]    retries_full;
  logic          busy;
  logic          rx_fail;
  logic          rx_reply;
  logic          rx_new_id;
  logic [2:0]    send_id;
  logic [2:0]    tx_id_inc;
  logic          adv_step;

  assign cmd_take     = cmd_valid && room;
  assign busy         = (retries_left != 4'd0);
  assign timer_load   = (TW'(crc_timeout) == '0) ? TW'(1) : TW'(crc_timeout);
  assign timer_dec    = crc_timer - 1'b1;
  assign retries_dec  = busy ? retries_left - 4'd1 : 4'd0;
  assign retries_full = {1'b0, retry_limit} + 4'd1;
  assign tx_id_inc    = tx_id + 3'd1;
  assign adv_step     = phy_gc || !tx_kind_gc;
  assign rx_fail      = busy && (!cmd.msg_is_goodcrc || !cmd.rx_is_sop ||
                                 cmd.rx_message_id != tx_id);
  assign rx_reply     = !cmd.msg_is_goodcrc && cmd.rx_is_sop && !monitor_only;
  assign rx_new_id    = !last_rx_valid || cmd.rx_message_id != last_rx_id;
  assign send_id      = (!phy_gc && cmd.msg_is_goodcrc) ? last_rx_id : tx_id;

  // Carry out one request: next state and up to two results.
  always_comb begin
    tx_id_next         = tx_id;
    retries_left_next  = retries_left;
    tx_kind_gc_next    = tx_kind_gc;
    crc_timer_next     = crc_timer;
    last_rx_id_next    = last_rx_id;
    last_rx_valid_next = last_rx_valid;
    spec_rev_next      = spec_rev;
    pending_next       = pending;
    cc_pin_next        = cc_pin;
    wr_res0            = '0;
    wr_res1            = '0;
    wr_count           = 2'd0;

    if (cmd_take) begin
      case (cmd.op)
        pdpl_pkg::OP_RESET: begin
          tx_id_next         = 3'd0;
          retries_left_next  = 4'd0;
          tx_kind_gc_next    = 1'b0;
          crc_timer_next     = '0;
          last_rx_id_next    = 3'd0;
          last_rx_valid_next = 1'b0;
          pending_next       = 1'b0;
          wr_res0.event_code = pdpl_pkg::EV_RESET;
          wr_count           = 2'd1;
        end

        pdpl_pkg::OP_SEND: begin
          wr_count = 2'd1;
          if (!busy) begin
            tx_kind_gc_next       = cmd.msg_is_goodcrc;
            retries_left_next     = retries_full;
            wr_res0.transmit      = 1'b1;
            wr_res0.tx_message_id = send_id;
            wr_res0.tx_spec_rev   = spec_rev;
            wr_res0.tx_is_goodcrc = cmd.msg_is_goodcrc;
            wr_res0.tx_cc         = cc_pin;
            wr_res0.send_accepted = 1'b1;
          end
        end

        pdpl_pkg::OP_TX_DONE: begin
          if (!cmd.tx_ok || phy_gc) begin
            retries_left_next = 4'd0;
            if (adv_step) begin
              tx_id_next = tx_id_inc;
            end
          end else if (!tx_kind_gc) begin
            crc_timer_next = timer_load;
          end else begin
            // A GoodCRC reply went out: deliver the message it answered.
            retries_left_next = 4'd0;
            if (pending) begin
              pending_next       = 1'b0;
              wr_res0.event_code = pdpl_pkg::EV_MSG_RECEIVED;
              wr_count           = 2'd1;
            end
          end
        end

        pdpl_pkg::OP_RX_MSG: begin
          if (phy_gc) begin
            wr_res0.event_code = pdpl_pkg::EV_MSG_RECEIVED;
            wr_count           = 2'd1;
          end else begin
            // Any message ends a transmission that waits for its GoodCRC.
            if (busy) begin
              crc_timer_next    = '0;
              retries_left_next = 4'd0;
              pending_next      = 1'b0;
              if (!tx_kind_gc) begin
                tx_id_next = tx_id_inc;
              end
            end
            if (rx_reply) begin
              // Duplicate IDs get a GoodCRC but no second delivery.
              if (rx_new_id) begin
                pending_next       = 1'b1;
                last_rx_id_next    = cmd.rx_message_id;
                last_rx_valid_next = 1'b1;
                spec_rev_next      = cmd.rx_spec_rev;
              end
              tx_kind_gc_next       = 1'b1;
              retries_left_next     = retries_full;
              wr_res0.transmit      = 1'b1;
              wr_res0.tx_message_id = rx_new_id ? cmd.rx_message_id : last_rx_id;
              wr_res0.tx_spec_rev   = rx_new_id ? cmd.rx_spec_rev : spec_rev;
              wr_res0.tx_is_goodcrc = 1'b1;
              wr_res0.tx_cc         = cc_pin;
              if (rx_fail) begin
                wr_res1.event_code = pdpl_pkg::EV_TX_FAILED;
                wr_count           = 2'd2;
              end else begin
                wr_count = 2'd1;
              end
            end else if (rx_fail) begin
              wr_res0.event_code = pdpl_pkg::EV_TX_FAILED;
              wr_count           = 2'd1;
            end
          end
        end

        pdpl_pkg::OP_TICK: begin
          if (crc_timer != '0) begin
            crc_timer_next = timer_dec;
            if (timer_dec == '0) begin
              // Timeout: retry a normal message while budget remains, else give up the slot.
              if (retries_dec != 4'd0 && !tx_kind_gc) begin
                retries_left_next     = retries_dec;
                wr_res0.transmit      = 1'b1;
                wr_res0.tx_message_id = tx_id;
                wr_res0.tx_spec_rev   = spec_rev;
                wr_res0.tx_cc         = cc_pin;
                wr_count              = 2'd1;
              end else begin
                retries_left_next = 4'd0;
                if (adv_step) begin
                  tx_id_next = tx_id_inc;
                end
              end
            end
          end
        end

        pdpl_pkg::OP_CC: begin
          cc_pin_next        = cmd.cc_line;
          wr_res0.event_code = (cmd.cc_line == 2'd0) ? pdpl_pkg::EV_DISCONNECTED
                                                     : pdpl_pkg::EV_CONNECTED;
          wr_count           = 2'd1;
        end

        default: begin
        end
      endcase

      // Mark the final result of this request.
      if (wr_count == 2'd1) begin
        wr_res0.last = 1'b1;
      end else if (wr_count == 2'd2) begin
        wr_res1.last = 1'b1;
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phy_gc       <= 1'b0;
      monitor_only <= 1'b1;
      retry_limit  <= 3'd2;
      crc_timeout  <= 16'd1000;
    end else if (cfg_valid) begin
      case (cfg_index)
        pdpl_pkg::CFG_PHY_GOODCRC: phy_gc       <= cfg_data[0];
        pdpl_pkg::CFG_MONITOR:     monitor_only <= cfg_data[0];
        pdpl_pkg::CFG_RETRY_LIMIT: retry_limit  <= cfg_data[2:0];
        pdpl_pkg::CFG_CRC_TIMEOUT: crc_timeout  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Protocol state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_id         <= 3'd0;
      retries_left  <= 4'd0;
      tx_kind_gc    <= 1'b0;
      crc_timer     <= '0;
      last_rx_id    <= 3'd0;
      last_rx_valid <= 1'b0;
      spec_rev      <= 2'd1;
      pending       <= 1'b0;
      cc_pin        <= 2'd0;
    end else begin
      tx_id         <= tx_id_next;
      retries_left  <= retries_left_next;
      tx_kind_gc    <= tx_kind_gc_next;
      crc_timer     <= crc_timer_next;
      last_rx_id    <= last_rx_id_next;
      last_rx_valid <= last_rx_valid_next;
      spec_rev      <= spec_rev_next;
      pending       <= pending_next;
      cc_pin        <= cc_pin_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/pd_protocol_layer_sink_core.sv */
`default_nettype none
// USB Power Delivery protocol layer for a sink: it tracks the transmit message
// ID, sends GoodCRC replies unless the PHY does so or monitor mode is set, drops
// duplicate received IDs and retries a transmission when its GoodCRC does not
// arrive in time. One request can be pushed every clock cycle while the request
// queue is not full. A request sits in a two-entry queue and is then executed by
// the back end, which writes zero, one or two results into a four-entry result
// queue whose head drives the result ports. The result queue drains one result
// per cycle while pop is high, so requests that yield two results (a GoodCRC
// reply plus a transmit failure) outrun it and the back end waits for room. Op
// codes 6 and 7 are accepted and dropped. Configuration writes are taken in any
// cycle (cfg_ready is always high) and must only be issued while the block is idle.
module pd_protocol_layer_sink_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // Request side.
  input  wire logic        push,
  output logic             full,
  input  wire logic [2:0]  op,
  input  wire logic        msg_is_goodcrc,
  input  wire logic [2:0]  rx_message_id,
  input  wire logic        rx_is_sop,
  input  wire logic [1:0]  rx_spec_rev,
  input  wire logic        tx_ok,
  input  wire logic [1:0]  cc_line,
  // Result side.
  output logic             empty,
  input  wire logic        pop,
  output logic             transmit,
  output logic [2:0]       tx_message_id,
  output logic [1:0]       tx_spec_rev,
  output logic             tx_is_goodcrc,
  output logic [1:0]       tx_cc,
  output logic             send_accepted,
  output logic [2:0]       event_code,
  output logic             last,
  // Configuration write channel.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic            fe_wr_en;
  pdpl_pkg::cmd_t  fe_cmd;
  logic            cmd_valid;
  pdpl_pkg::cmd_t  cmd;
  logic            cmd_take;
  logic            room;
  logic [1:0]      wr_count;
  pdpl_pkg::res_t  wr_res0;
  pdpl_pkg::res_t  wr_res1;
  pdpl_pkg::res_t  rd_res;

  assign cfg_ready = 1'b1;

  pdpl_front u_front (
    .push           (push),
    .full           (full),
    .op             (op),
    .msg_is_goodcrc (msg_is_goodcrc),
    .rx_message_id  (rx_message_id),
    .rx_is_sop      (rx_is_sop),
    .rx_spec_rev    (rx_spec_rev),
    .tx_ok          (tx_ok),
    .cc_line        (cc_line),
    .wr_en          (fe_wr_en),
    .wr_cmd         (fe_cmd)
  );

  pdpl_cmd_queue u_cmd_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (fe_wr_en),
    .wr_cmd   (fe_cmd),
    .full     (full),
    .rd_en    (cmd_take),
    .rd_valid (cmd_valid),
    .rd_cmd   (cmd)
  );

  pdpl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .room      (room),
    .wr_count  (wr_count),
    .wr_res0   (wr_res0),
    .wr_res1   (wr_res1)
  );

  pdpl_res_queue u_res_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_count (wr_count),
    .wr_res0  (wr_res0),
    .wr_res1  (wr_res1),
    .room     (room),
    .empty    (empty),
    .pop      (pop),
    .rd_res   (rd_res)
  );

  assign transmit      = rd_res.transmit;
  assign tx_message_id = rd_res.tx_message_id;
  assign tx_spec_rev   = rd_res.tx_spec_rev;
  assign tx_is_goodcrc = rd_res.tx_is_goodcrc;
  assign tx_cc         = rd_res.tx_cc;
  assign send_accepted = rd_res.send_accepted;
  assign event_code    = rd_res.event_code;
  assign last          = rd_res.last;

endmodule
`default_nettype wire
